// File: rtl/nbody_gravity_step_macros.svh
// assertion macros for the n-body gravity step checker
`ifndef NBODY_GRAVITY_STEP_MACROS_SVH
`define NBODY_GRAVITY_STEP_MACROS_SVH

// same-cycle implication
`define NBG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("nbg assertion failed");

// next-cycle implication
`define NBG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("nbg assertion failed");

`endif

// File: rtl/nbg_pkg.sv
// shared types, constants and helpers for the n-body gravity step
package nbg_pkg;

    localparam int MAX_BODIES_DEF = 16;
    localparam int CFG_W          = 32;
    localparam int COUNT_W        = 5;
    localparam int ROOT_W         = 32;
    localparam int QUOT_W         = 64;

    localparam logic [31:0]        GRAV_RESET  = 32'd65536;
    localparam logic [31:0]        DT_RESET    = 32'd6554;
    localparam logic [31:0]        SOFT_RESET  = 32'd655;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd5;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef enum logic [1:0] {
        CFG_GRAV  = 2'd0,
        CFG_DT    = 2'd1,
        CFG_SOFT  = 2'd2,
        CFG_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAIR,
        ST_DRAIN,
        ST_RD,
        ST_MV,
        ST_V,
        ST_MP,
        ST_P,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              action;
        logic [3:0]        body_index;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
        logic [31:0]       load_mass;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        out_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic              is_last;
    } out_item_t;

    // control that travels with each pair through the pair unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic fin;
    } pair_tag_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/nbg_sqrt_cell.sv
// one stage of the pipelined square root chain, one result bit per cell
module nbg_sqrt_cell
    import nbg_pkg::*;
#(
    parameter int RW     = ROOT_W,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pair_tag_t         tag_in,
    input  logic [2*RW-1:0]   rad_in,
    input  logic [RW+2:0]     rem_in,
    input  logic [RW-1:0]     root_in,
    input  logic [SIDE_W-1:0] side_in,
    output pair_tag_t         tag_out,
    output logic [2*RW-1:0]   rad_out,
    output logic [RW+2:0]     rem_out,
    output logic [RW-1:0]     root_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          take;

    assign rem_sh = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_out <= '0;
        else
            tag_out <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        rad_out  <= {rad_in[2*RW-3:0], 2'b00};
        rem_out  <= take ? (rem_sh - trial) : rem_sh;
        root_out <= {root_in[RW-2:0], take};
        side_out <= side_in;
    end

endmodule

// File: rtl/nbg_div_cell.sv
// one stage of the pipelined restoring divider chain, one quotient bit per cell
module nbg_div_cell
    import nbg_pkg::*;
#(
    parameter int QW     = QUOT_W,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pair_tag_t         tag_in,
    input  logic [QW-1:0]     nq_in,
    input  logic [QW-1:0]     rem_in,
    input  logic [QW-1:0]     den_in,
    input  logic [SIDE_W-1:0] side_in,
    output pair_tag_t         tag_out,
    output logic [QW-1:0]     nq_out,
    output logic [QW-1:0]     rem_out,
    output logic [QW-1:0]     den_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [QW:0] rem_sh;
    logic [QW:0] diff;
    logic        take;

    assign rem_sh = {rem_in, nq_in[QW-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign take   = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_out <= '0;
        else
            tag_out <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        nq_out   <= {nq_in[QW-2:0], take};
        rem_out  <= take ? diff[QW-1:0] : rem_sh[QW-1:0];
        den_out  <= den_in;
        side_out <= side_in;
    end

endmodule

// File: rtl/nbg_pair_unit.sv
// pipelined softened-gravity pair unit: differences, root chain, cube, divider chain, terms
module nbg_pair_unit
    import nbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pair_tag_t          tag_in,
    input  logic signed [31:0] pix,
    input  logic signed [31:0] piy,
    input  logic signed [31:0] pjx,
    input  logic signed [31:0] pjy,
    input  logic [31:0]        mass_j,
    input  logic [31:0]        grav,
    input  logic [31:0]        soft_sq,
    output pair_tag_t          tag_out,
    output logic signed [31:0] term_x,
    output logic signed [31:0] term_y
);

    localparam int SQ_SIDE_W = 48 + 48 + 32 + 32 + 2;
    localparam int DV_SIDE_W = 32 + 32 + 2 + 1;

    // difference stage
    pair_tag_t          t1_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [63:0]        gmf_reg;
    logic signed [32:0] dx_full, dy_full;

    assign dx_full = {pjx[31], pjx} - {pix[31], pix};
    assign dy_full = {pjy[31], pjy} - {piy[31], piy};

    // square stage
    pair_tag_t          t2_reg;
    logic signed [63:0] sqx_reg, sqy_reg;
    logic [31:0]        magx_reg, magy_reg;
    logic               sgnx_reg, sgny_reg;
    logic [47:0]        gm_reg;

    // softened distance stage
    pair_tag_t          t3_reg;
    logic [47:0]        s_reg;
    logic [47:0]        gm3_reg;
    logic [31:0]        magx3_reg, magy3_reg;
    logic               sgnx3_reg, sgny3_reg;
    logic [63:0]        sq_sum;

    assign sq_sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else
        begin
            t1_reg <= tag_in;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= sat32(64'(dx_full));
        dy_reg    <= sat32(64'(dy_full));
        gmf_reg   <= grav * mass_j;
        sqx_reg   <= dx_reg * dx_reg;
        sqy_reg   <= dy_reg * dy_reg;
        magx_reg  <= dx_reg[31] ? (~dx_reg + 32'd1) : dx_reg;
        magy_reg  <= dy_reg[31] ? (~dy_reg + 32'd1) : dy_reg;
        sgnx_reg  <= dx_reg[31];
        sgny_reg  <= dy_reg[31];
        gm_reg    <= gmf_reg[63:16];
        s_reg     <= sq_sum[63:16] + {16'd0, soft_sq};
        gm3_reg   <= gm_reg;
        magx3_reg <= magx_reg;
        magy3_reg <= magy_reg;
        sgnx3_reg <= sgnx_reg;
        sgny3_reg <= sgny_reg;
    end

    // square root chain
    pair_tag_t             sq_tag  [0:ROOT_W];
    logic [2*ROOT_W-1:0]   sq_rad  [0:ROOT_W];
    logic [ROOT_W+2:0]     sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]     sq_root [0:ROOT_W];
    logic [SQ_SIDE_W-1:0]  sq_side [0:ROOT_W];

    assign sq_tag[0]  = t3_reg;
    assign sq_rad[0]  = {s_reg, 16'd0};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {s_reg, gm3_reg, magx3_reg, magy3_reg, sgnx3_reg, sgny3_reg};

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        nbg_sqrt_cell #(.RW(ROOT_W), .SIDE_W(SQ_SIDE_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (sq_tag[k]),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .side_in  (sq_side[k]),
            .tag_out  (sq_tag[k+1]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .side_out (sq_side[k+1])
        );
    end

    logic [47:0] s_q, gm_q;
    logic [31:0] magx_q, magy_q;
    logic        sgnx_q, sgny_q;

    assign {s_q, gm_q, magx_q, magy_q, sgnx_q, sgny_q} = sq_side[ROOT_W];

    // cube stage: partial products then combine with saturation
    pair_tag_t   t4_reg, t5_reg;
    logic [47:0] mh_reg;
    logic [63:0] ml_reg;
    logic [47:0] gm4_reg, gm5_reg;
    logic [31:0] magx4_reg, magy4_reg, magx5_reg, magy5_reg;
    logic        sgnx4_reg, sgny4_reg, sgnx5_reg, sgny5_reg;
    logic [63:0] r3_reg;
    logic        r3z_reg;
    logic [64:0] r3_sum;

    assign r3_sum = {1'b0, mh_reg, 16'd0} + {17'd0, ml_reg[63:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else
        begin
            t4_reg <= sq_tag[ROOT_W];
            t5_reg <= t4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mh_reg    <= s_q[47:32] * sq_root[ROOT_W];
        ml_reg    <= s_q[31:0] * sq_root[ROOT_W];
        gm4_reg   <= gm_q;
        magx4_reg <= magx_q;
        magy4_reg <= magy_q;
        sgnx4_reg <= sgnx_q;
        sgny4_reg <= sgny_q;
        r3_reg    <= r3_sum[64] ? '1 : r3_sum[63:0];
        r3z_reg   <= (mh_reg == '0) && (ml_reg[63:16] == '0);
        gm5_reg   <= gm4_reg;
        magx5_reg <= magx4_reg;
        magy5_reg <= magy4_reg;
        sgnx5_reg <= sgnx4_reg;
        sgny5_reg <= sgny4_reg;
    end

    // divider chain
    pair_tag_t            dv_tag  [0:QUOT_W];
    logic [QUOT_W-1:0]    dv_nq   [0:QUOT_W];
    logic [QUOT_W-1:0]    dv_rem  [0:QUOT_W];
    logic [QUOT_W-1:0]    dv_den  [0:QUOT_W];
    logic [DV_SIDE_W-1:0] dv_side [0:QUOT_W];

    assign dv_tag[0]  = t5_reg;
    assign dv_nq[0]   = {gm5_reg, 16'd0};
    assign dv_rem[0]  = '0;
    assign dv_den[0]  = r3_reg;
    assign dv_side[0] = {magx5_reg, magy5_reg, sgnx5_reg, sgny5_reg, r3z_reg};

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        nbg_div_cell #(.QW(QUOT_W), .SIDE_W(DV_SIDE_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (dv_tag[k]),
            .nq_in    (dv_nq[k]),
            .rem_in   (dv_rem[k]),
            .den_in   (dv_den[k]),
            .side_in  (dv_side[k]),
            .tag_out  (dv_tag[k+1]),
            .nq_out   (dv_nq[k+1]),
            .rem_out  (dv_rem[k+1]),
            .den_out  (dv_den[k+1]),
            .side_out (dv_side[k+1])
        );
    end

    logic [31:0] magx_d, magy_d;
    logic        sgnx_d, sgny_d, zero_d;
    logic [63:0] f_d;

    assign {magx_d, magy_d, sgnx_d, sgny_d, zero_d} = dv_side[QUOT_W];
    assign f_d = zero_d ? '0 : dv_nq[QUOT_W];

    // term stage
    pair_tag_t   t6_reg, t7_reg;
    logic [63:0] hx_reg, lx_reg, hy_reg, ly_reg;
    logic        sgnx6_reg, sgny6_reg;
    logic [31:0] resx, resy;

    function automatic logic [31:0] term_mag(input logic [63:0] h, input logic [63:0] l);
        logic [49:0] t;
        logic [31:0] r;
        t = {3'd0, h[30:0], 16'd0} + {2'd0, l[63:16]};
        if (h >= 64'd32768 || t > 50'h80000000)
            r = 32'h80000000;
        else
            r = t[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] term_sgn(input logic [31:0] m, input logic s);
        logic signed [31:0] r;
        if (s)
            r = ~m + 32'd1;
        else if (m == 32'h80000000)
            r = 32'sh7fffffff;
        else
            r = m;
        return r;
    endfunction

    assign resx = term_mag(hx_reg, lx_reg);
    assign resy = term_mag(hy_reg, ly_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t6_reg <= '0;
            t7_reg <= '0;
        end
        else
        begin
            t6_reg <= dv_tag[QUOT_W];
            t7_reg <= t6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hx_reg    <= magx_d * f_d[63:32];
        lx_reg    <= magx_d * f_d[31:0];
        hy_reg    <= magy_d * f_d[63:32];
        ly_reg    <= magy_d * f_d[31:0];
        sgnx6_reg <= sgnx_d;
        sgny6_reg <= sgny_d;
        term_x    <= term_sgn(resx, sgnx6_reg);
        term_y    <= term_sgn(resy, sgny6_reg);
    end

    assign tag_out = t7_reg;

endmodule

// File: rtl/nbody_gravity_step.sv
// top level of the softened direct-sum n-body gravity step
//
// in channel (in_valid/in_ready/in_data): a load transaction writes one body into its
// slot; a step transaction runs a whole time step and is followed by one out
// transaction per active body, in slot order, is_last marking the final one.
// in_ready is high only while the block is idle, so a step completes before the next
// transaction is taken.
// a step issues one pair a cycle through the pipelined pair unit (the diagonal slots
// left as bubbles), then drains the pair pipeline (32 root cells, 64 divider cells and
// the arithmetic stages around them), then updates each body in the states ST_RD,
// ST_MV, ST_V, ST_MP, ST_P and ST_OUT. with a single body the pair phase is skipped.
// out_valid holds the body until out_ready; a stall simply stretches the update phase.
// cfg_we writes a register and must only be used while idle, which is not enforced.
// reset returns the registers to their defaults and the controller to idle; the body
// store has no reset, and a slot must be read only after it is loaded (not enforced).
module nbody_gravity_step
    import nbg_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_BODIES);
    localparam int CNT_W = $clog2(MAX_BODIES + 1);

    // configuration
    logic [31:0]        grav_reg, dt_reg, soft_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg  <= GRAV_RESET;
            dt_reg    <= DT_RESET;
            soft_reg  <= SOFT_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRAV:  grav_reg  <= cfg_data[31:0];
                CFG_DT:    dt_reg    <= cfg_data[31:0];
                CFG_SOFT:  soft_reg  <= cfg_data[31:0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // control
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, row_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             single_reg, single_next;

    logic       in_take, load_take, step_take, load_ok;
    logic       i_end, j_end, j_end2;
    pair_tag_t  tag_issue, tag_mem_reg, tag_term;
    logic       acc_wr;
    logic [CNT_W-1:0] n_start;

    assign in_take   = in_valid && in_ready;
    assign load_take = in_take && (in_data.action == ACTION_LOAD);
    assign step_take = in_take && (in_data.action == ACTION_STEP);
    assign load_ok   = 32'(in_data.body_index) < 32'(MAX_BODIES);

    assign i_end  = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign j_end  = (CNT_W'(j_reg) + CNT_W'(1)) == n_reg;
    assign j_end2 = (CNT_W'(j_reg) + CNT_W'(2)) == n_reg;

    always_comb
    begin
        if (count_reg == '0)
            n_start = CNT_W'(1);
        else if (32'(count_reg) > 32'(MAX_BODIES))
            n_start = CNT_W'(MAX_BODIES);
        else
            n_start = CNT_W'(count_reg);
    end

    always_comb
    begin
        tag_issue.valid = (state_reg == ST_PAIR) && (i_reg != j_reg);
        tag_issue.first = ((j_reg == '0) && (i_reg != '0))
                       || ((j_reg == IDX_W'(1)) && (i_reg == '0));
        tag_issue.last  = i_end ? j_end2 : j_end;
        tag_issue.fin   = tag_issue.last && i_end;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        single_next = single_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (step_take)
                begin
                    n_next      = n_start;
                    single_next = (n_start == CNT_W'(1));
                    i_next      = '0;
                    j_next      = '0;
                    state_next  = (n_start == CNT_W'(1)) ? ST_RD : ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                        state_next = ST_DRAIN;
                    else
                        i_next = i_reg + IDX_W'(1);
                end
                else
                    j_next = j_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (acc_wr && tag_term.fin)
                begin
                    i_next     = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: state_next = ST_MV;
            ST_MV: state_next = ST_V;
            ST_V:  state_next = ST_MP;
            ST_MP: state_next = ST_P;
            ST_P:  state_next = ST_OUT;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (i_end)
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= CNT_W'(1);
            single_reg  <= 1'b0;
            tag_mem_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            single_reg  <= single_next;
            tag_mem_reg <= tag_issue;
        end
    end

    // body store
    logic signed [31:0] mem_px_reg [MAX_BODIES];
    logic signed [31:0] mem_py_reg [MAX_BODIES];
    logic signed [31:0] mem_vx_reg [MAX_BODIES];
    logic signed [31:0] mem_vy_reg [MAX_BODIES];
    logic [31:0]        mem_m_reg  [MAX_BODIES];
    logic signed [31:0] mem_ax_reg [MAX_BODIES];
    logic signed [31:0] mem_ay_reg [MAX_BODIES];

    logic signed [31:0] pix_reg, piy_reg, pjx_reg, pjy_reg, vix_reg, viy_reg;
    logic signed [31:0] aix_reg, aiy_reg;
    logic [31:0]        mj_reg;

    logic [IDX_W-1:0]   ld_addr;
    logic               body_we;
    logic [IDX_W-1:0]   body_addr;
    logic signed [31:0] wr_px, wr_py, wr_vx, wr_vy;
    logic signed [31:0] newpx, newpy;
    logic signed [31:0] vx_reg, vy_reg;

    assign ld_addr   = IDX_W'(in_data.body_index);
    assign body_we   = (load_take && load_ok) || (state_reg == ST_P);
    assign body_addr = load_take ? ld_addr : i_reg;
    assign wr_px     = load_take ? in_data.load_pos_x : newpx;
    assign wr_py     = load_take ? in_data.load_pos_y : newpy;
    assign wr_vx     = load_take ? in_data.load_vel_x : vx_reg;
    assign wr_vy     = load_take ? in_data.load_vel_y : vy_reg;

    always_ff @(posedge clk)
    begin
        if (body_we)
        begin
            mem_px_reg[body_addr] <= wr_px;
            mem_py_reg[body_addr] <= wr_py;
            mem_vx_reg[body_addr] <= wr_vx;
            mem_vy_reg[body_addr] <= wr_vy;
        end
        if (load_take && load_ok)
            mem_m_reg[ld_addr] <= in_data.load_mass;
        pix_reg <= mem_px_reg[i_reg];
        piy_reg <= mem_py_reg[i_reg];
        pjx_reg <= mem_px_reg[j_reg];
        pjy_reg <= mem_py_reg[j_reg];
        vix_reg <= mem_vx_reg[i_reg];
        viy_reg <= mem_vy_reg[i_reg];
        mj_reg  <= mem_m_reg[j_reg];
    end

    // pair unit and acceleration accumulation
    logic signed [31:0] term_x, term_y;
    logic signed [31:0] accx_reg, accy_reg;
    logic signed [31:0] accx_sum, accy_sum;
    logic signed [31:0] acc_wx, acc_wy;
    logic               acc_we;
    logic [IDX_W-1:0]   acc_addr;

    nbg_pair_unit u_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_mem_reg),
        .pix     (pix_reg),
        .piy     (piy_reg),
        .pjx     (pjx_reg),
        .pjy     (pjy_reg),
        .mass_j  (mj_reg),
        .grav    (grav_reg),
        .soft_sq (soft_reg),
        .tag_out (tag_term),
        .term_x  (term_x),
        .term_y  (term_y)
    );

    assign acc_wr   = tag_term.valid && tag_term.last;
    assign accx_sum = sat32(64'(tag_term.first ? 32'sd0 : accx_reg) + 64'(term_x));
    assign accy_sum = sat32(64'(tag_term.first ? 32'sd0 : accy_reg) + 64'(term_y));
    assign acc_we   = (load_take && load_ok) || acc_wr;
    assign acc_addr = load_take ? ld_addr : row_reg;
    assign acc_wx   = load_take ? 32'sd0 : accx_sum;
    assign acc_wy   = load_take ? 32'sd0 : accy_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else if (step_take)
            row_reg <= '0;
        else if (acc_wr)
            row_reg <= row_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (tag_term.valid)
        begin
            accx_reg <= accx_sum;
            accy_reg <= accy_sum;
        end
        if (acc_we)
        begin
            mem_ax_reg[acc_addr] <= acc_wx;
            mem_ay_reg[acc_addr] <= acc_wy;
        end
        aix_reg <= mem_ax_reg[i_reg];
        aiy_reg <= mem_ay_reg[i_reg];
    end

    // semi-implicit euler update
    logic signed [64:0] pax_reg, pay_reg, pvx_reg, pvy_reg;
    logic signed [32:0] dt_s;
    logic signed [31:0] ax_use, ay_use;
    out_item_t          out_reg;

    assign dt_s   = {1'b0, dt_reg};
    assign ax_use = single_reg ? 32'sd0 : aix_reg;
    assign ay_use = single_reg ? 32'sd0 : aiy_reg;
    assign newpx  = sat32(64'(pix_reg) + 64'(pvx_reg >>> 16));
    assign newpy  = sat32(64'(piy_reg) + 64'(pvy_reg >>> 16));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MV)
        begin
            pax_reg <= ax_use * dt_s;
            pay_reg <= ay_use * dt_s;
        end
        if (state_reg == ST_V)
        begin
            vx_reg <= sat32(64'(vix_reg) + 64'(pax_reg >>> 16));
            vy_reg <= sat32(64'(viy_reg) + 64'(pay_reg >>> 16));
        end
        if (state_reg == ST_MP)
        begin
            pvx_reg <= vx_reg * dt_s;
            pvy_reg <= vy_reg * dt_s;
        end
        if (state_reg == ST_P)
        begin
            out_reg.out_index <= 4'(i_reg);
            out_reg.out_pos_x <= newpx;
            out_reg.out_pos_y <= newpy;
            out_reg.out_vel_x <= vx_reg;
            out_reg.out_vel_y <= vy_reg;
            out_reg.is_last   <= i_end;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/nbg_checker.sv
// port-level checker for the n-body gravity step, bound to the top level
`include "nbody_gravity_step_macros.svh"

module nbg_checker
    import nbg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `NBG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `NBG_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `NBG_ASSERT_NXT(a_load_quick, clk, rst_n, in_valid && in_ready && (in_data.action == ACTION_LOAD), in_ready)
    `NBG_ASSERT_NXT(a_step_busy, clk, rst_n, in_valid && in_ready && (in_data.action == ACTION_STEP), !in_ready)
    `NBG_ASSERT_NXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_data.is_last, in_ready)

endmodule

bind nbody_gravity_step nbg_checker u_nbg_checker (.*);

// File: verif/nbody_gravity_step_checker.sv
// checker for the n-body gravity step: tracks bodies and registers, predicts and compares
`timescale 1ns / 1ps

module nbody_gravity_step_checker
    import nbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_data,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int SLOTS = 16;

    bit [31:0]        grav;
    bit [31:0]        dt;
    bit [31:0]        soft_sq;
    bit [4:0]         count;
    bit signed [31:0] pos_x [SLOTS];
    bit signed [31:0] pos_y [SLOTS];
    bit signed [31:0] vel_x [SLOTS];
    bit signed [31:0] vel_y [SLOTS];
    bit [31:0]        mass  [SLOTS];
    out_item_t        expected_bodies [$];

    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] pull_factor(input longint dx, input longint dy,
                                              input bit [31:0] m);
        bit [63:0] sum;
        bit [63:0] s;
        bit [63:0] r;
        bit [63:0] a;
        bit [63:0] r3;
        bit [63:0] gm;
        sum = 64'(dx * dx) + 64'(dy * dy);
        s   = (sum >> 16) + {32'b0, soft_sq};
        r   = int_sqrt(s << 16);
        a   = ((s >> 32) * r) << 16;
        r3  = a + (({32'b0, s[31:0]} * r) >> 16);
        if (r3 < a)
            r3 = '1;
        if (r3 == 0)
            return 0;
        gm = ({32'b0, grav} * {32'b0, m}) >> 16;
        return (gm << 16) / r3;
    endfunction

    function automatic longint axis_pull(input longint d, input bit [63:0] f);
        bit [63:0] mag;
        bit [63:0] hi;
        bit [63:0] res;
        mag = d < 0 ? 64'(-d) : 64'(d);
        hi  = mag * (f >> 32);
        if (hi >= 64'd32768)
            res = 64'd2147483648;
        else
        begin
            res = (hi << 16) + ((mag * {32'b0, f[31:0]}) >> 16);
            if (res > 64'd2147483648)
                res = 64'd2147483648;
        end
        return d < 0 ? -longint'(res) : longint'(res);
    endfunction

    function automatic int advance_bodies();
        int        n;
        longint    ax;
        longint    ay;
        longint    dx;
        longint    dy;
        longint    vx;
        longint    vy;
        longint    px;
        longint    py;
        longint    step;
        bit [63:0] f;
        longint    acc_x [SLOTS];
        longint    acc_y [SLOTS];
        out_item_t o;
        n = count;
        if (n < 1)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        for (int i = 0; i < n; i++)
        begin
            ax = 0;
            ay = 0;
            for (int j = 0; j < n; j++)
            begin
                if (i != j)
                begin
                    dx = clamp_word(longint'(pos_x[j]) - longint'(pos_x[i]));
                    dy = clamp_word(longint'(pos_y[j]) - longint'(pos_y[i]));
                    f  = pull_factor(dx, dy, mass[j]);
                    ax = clamp_word(ax + clamp_word(axis_pull(dx, f)));
                    ay = clamp_word(ay + clamp_word(axis_pull(dy, f)));
                end
            end
            acc_x[i] = ax;
            acc_y[i] = ay;
        end
        step = longint'({32'b0, dt});
        for (int i = 0; i < n; i++)
        begin
            vx = clamp_word(longint'(vel_x[i]) + ((acc_x[i] * step) >>> 16));
            vy = clamp_word(longint'(vel_y[i]) + ((acc_y[i] * step) >>> 16));
            px = clamp_word(longint'(pos_x[i]) + ((vx * step) >>> 16));
            py = clamp_word(longint'(pos_y[i]) + ((vy * step) >>> 16));
            vel_x[i] = vx[31:0];
            vel_y[i] = vy[31:0];
            pos_x[i] = px[31:0];
            pos_y[i] = py[31:0];
            o.out_index = i[3:0];
            o.out_pos_x = px[31:0];
            o.out_pos_y = py[31:0];
            o.out_vel_x = vx[31:0];
            o.out_vel_y = vy[31:0];
            o.is_last   = (i + 1 == n);
            expected_bodies.push_back(o);
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int        added;
        int        popped;
        out_item_t want;
        if (!rst_n)
        begin
            grav    = GRAV_RESET;
            dt      = DT_RESET;
            soft_sq = SOFT_RESET;
            count   = COUNT_RESET;
            expected_bodies.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            added  = 0;
            popped = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRAV:  grav    = cfg_data;
                    CFG_DT:    dt      = cfg_data;
                    CFG_SOFT:  soft_sq = cfg_data;
                    CFG_COUNT: count   = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                popped = 1;
                if (expected_bodies.size() == 0)
                begin
                    $error("body transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_bodies.pop_front();
                    if (out_data !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (out_data.out_index !== want.out_index)
                            $error("out_index exp %0d got %0d",
                                   want.out_index, out_data.out_index);
                        if (out_data.out_pos_x !== want.out_pos_x)
                            $error("out_pos_x exp %0d got %0d",
                                   want.out_pos_x, out_data.out_pos_x);
                        if (out_data.out_pos_y !== want.out_pos_y)
                            $error("out_pos_y exp %0d got %0d",
                                   want.out_pos_y, out_data.out_pos_y);
                        if (out_data.out_vel_x !== want.out_vel_x)
                            $error("out_vel_x exp %0d got %0d",
                                   want.out_vel_x, out_data.out_vel_x);
                        if (out_data.out_vel_y !== want.out_vel_y)
                            $error("out_vel_y exp %0d got %0d",
                                   want.out_vel_y, out_data.out_vel_y);
                        if (out_data.is_last !== want.is_last)
                            $error("is_last exp %0d got %0d",
                                   want.is_last, out_data.is_last);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.action == ACTION_LOAD)
                begin
                    pos_x[in_data.body_index] = in_data.load_pos_x;
                    pos_y[in_data.body_index] = in_data.load_pos_y;
                    vel_x[in_data.body_index] = in_data.load_vel_x;
                    vel_y[in_data.body_index] = in_data.load_vel_y;
                    mass[in_data.body_index]  = in_data.load_mass;
                end
                else
                    added = advance_bodies();
            end
            pending <= pending + added - popped;
        end
    end

endmodule

// File: verif/nbody_gravity_step_tb.sv
// testbench top for the n-body gravity step: stimulus, idling, pressure and verdict
`timescale 1ns / 1ps

module nbody_gravity_step_tb
    import nbg_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 12;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    int               send_idle_pct;
    int               recv_stall_pct;
    logic             hold_start;
    int               hold_left = 0;

    nbody_gravity_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    nbody_gravity_step_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic in_item_t body_load(input logic [3:0] slot, input logic [31:0] px,
                                           input logic [31:0] py, input logic [31:0] vx,
                                           input logic [31:0] vy, input logic [31:0] m);
        in_item_t t;
        t.action     = ACTION_LOAD;
        t.body_index = slot;
        t.load_pos_x = px;
        t.load_pos_y = py;
        t.load_vel_x = vx;
        t.load_vel_y = vy;
        t.load_mass  = m;
        return t;
    endfunction

    function automatic in_item_t step_cmd();
        in_item_t t;
        t = body_load(4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        t.action = ACTION_STEP;
        return t;
    endfunction

    function automatic logic [31:0] near_value(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic in_item_t random_load();
        in_item_t t;
        if ($urandom_range(3) == 0)
            t = body_load(4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            t = body_load(4'($urandom), near_value(1 << 22), near_value(1 << 22),
                          near_value(1 << 18), near_value(1 << 18),
                          $urandom_range(1 << 19));
        return t;
    endfunction

    function automatic logic [31:0] pick_reg(input logic [31:0] nominal);
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hffffffff;
            default: return $urandom_range(nominal * 4);
        endcase
    endfunction

    task automatic send(input in_item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_GRAV;
        cfg_data       <= '0;
        hold_start     <= 1'b0;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(body_load(4'd0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'hffffffff));
        send(body_load(4'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'hffffffff));
        send(body_load(4'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        for (int k = 3; k < 16; k++)
            send(body_load(k[3:0], near_value(1 << 20), near_value(1 << 20),
                           near_value(1 << 16), near_value(1 << 16),
                           $urandom_range(1 << 18)));
        send(step_cmd());
        settle();
        write_reg(CFG_COUNT, 32'd16);
        send(step_cmd());
        settle();
        write_reg(CFG_SOFT, 32'd0);
        write_reg(CFG_COUNT, 32'd2);
        send(body_load(4'd0, 32'h00010000, 32'h00020000, 32'd0, 32'd0, 32'h00010000));
        send(body_load(4'd1, 32'h00010000, 32'h00020000, 32'd0, 32'd0, 32'h00010000));
        send(step_cmd());
        settle();
        write_reg(CFG_COUNT, 32'd0);
        send(step_cmd());
        settle();
        write_reg(CFG_COUNT, 32'd31);
        send(step_cmd());
        settle();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  <= (ph == 1) ? 73 : (ph == 3) ? 19 : 0;
            recv_stall_pct <= (ph == 2) ? 73 : (ph == 3) ? 19 : 0;
            write_reg(CFG_GRAV, pick_reg(32'd65536));
            write_reg(CFG_DT, pick_reg(32'd6554));
            write_reg(CFG_SOFT, pick_reg(32'd655));
            write_reg(CFG_COUNT, ($urandom_range(4) == 0) ? 32'($urandom & 32'h1f)
                                                          : 32'($urandom_range(16, 1)));
            for (int k = 0; k < 24; k++)
            begin
                if ($urandom_range(9) < 3)
                    send(step_cmd());
                else
                    send(random_load());
            end
            settle();
        end

        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        write_reg(CFG_GRAV, 32'd65536);
        write_reg(CFG_DT, 32'd6554);
        write_reg(CFG_SOFT, 32'd655);
        write_reg(CFG_COUNT, 32'd16);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        send(step_cmd());
        send(random_load());
        send(step_cmd());
        settle();

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
